FILE: rtl/pol_pkg.sv
package pol_pkg;

  localparam int unsigned ListDepthDef  = 16;
  localparam int unsigned ValueLimitDef = 100;

  localparam int unsigned ReqW   = 4;
  localparam int unsigned PosW   = 8;
  localparam int unsigned ValW   = 7;
  localparam int unsigned IndexW = 4;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_INS_HEAD = 4'd0,
    REQ_INS_POS  = 4'd1,
    REQ_INS_TAIL = 4'd2,
    REQ_READ     = 4'd3,
    REQ_DEL_HEAD = 4'd4,
    REQ_DEL_POS  = 4'd5,
    REQ_DEL_TAIL = 4'd6,
    REQ_CLEAR    = 4'd7,
    REQ_DUMP     = 4'd8
  } req_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_NOPOS  = 3'd2,
    STAT_APPEND = 3'd3,
    STAT_FULL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [PosW-1:0] at;
    logic [PosW-1:0] cnt;
  } cell_ctrl_t;

endpackage

FILE: rtl/pol_cell.sv
module pol_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                      clk_i,
  input  pol_pkg::cell_ctrl_t       ctrl_i,
  input  logic [pol_pkg::ValW-1:0]  new_i,
  input  logic [pol_pkg::ValW-1:0]  left_i,
  input  logic [pol_pkg::ValW-1:0]  right_i,
  input  logic [pol_pkg::ValW-1:0]  head_i,
  output logic [pol_pkg::ValW-1:0]  value_o
);
  import pol_pkg::*;

  localparam logic [PosW-1:0] IdxV  = PosW'(IDX);
  localparam logic [PosW-1:0] IdxNx = PosW'(IDX + 1);

  logic [ValW-1:0] value_q;
  logic [ValW-1:0] value_d;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (IdxV == ctrl_i.at) begin
          value_d = new_i;
        end else if (IdxV > ctrl_i.at && IdxV <= ctrl_i.cnt) begin
          value_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (IdxV >= ctrl_i.at && IdxNx < ctrl_i.cnt) begin
          value_d = right_i;
        end
      end
      CELL_ROTATE: begin
        if (IdxNx < ctrl_i.cnt) begin
          value_d = right_i;
        end else if (IdxNx == ctrl_i.cnt) begin
          value_d = head_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: rtl/positional_ordered_list.sv
// Positional ordered list: a bounded list of small values held in a row of
// cells, one value per cell, in list order from cell zero.
// A transaction is taken at a rising edge where start_i is high and busy_o
// is low; it carries req_type_i, position_i and entry_value_i. Inserts and
// deletes shift the cells, reads and clear do not; each of them gives one
// result in the cycle after the transaction, so such requests can follow
// each other in every cycle. A dump of a non-empty list gives one result per
// element on consecutive cycles, the first in the cycle after the
// transaction, by rotating the occupied cells towards cell zero; busy_o is
// high until the last of them is registered. Each result is shown for
// exactly one cycle with valid_o high; last_of_run_o marks the final result
// of a transaction. The receiver cannot hold results off and must take each
// one as it appears. Reset clears the element count and the controller;
// cell contents are not reset, as entries beyond the count are never shown.
module positional_ordered_list #(
  parameter int unsigned LIST_DEPTH  = pol_pkg::ListDepthDef,
  parameter int unsigned VALUE_LIMIT = pol_pkg::ValueLimitDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [pol_pkg::ReqW-1:0]     req_type_i,
  input  logic [pol_pkg::PosW-1:0]     position_i,
  input  logic [pol_pkg::ValW-1:0]     entry_value_i,
  output logic                         valid_o,
  output logic [pol_pkg::ValW-1:0]     item_value_o,
  output logic [pol_pkg::IndexW-1:0]   item_index_o,
  output logic [pol_pkg::StatW-1:0]    status_o,
  output logic [pol_pkg::CountW-1:0]   entry_count_o,
  output logic                         last_of_run_o
);
  import pol_pkg::*;

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(LIST_DEPTH);
  localparam int unsigned ModN = 2 ** ValW;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    count_d;
  logic [IdxW-1:0]    dump_idx_q;
  logic               valid_q;
  logic               last_q;
  logic [ValW-1:0]    value_q;
  logic [IndexW-1:0]  index_q;
  status_e            status_q;

  logic               accept;
  logic               full;
  logic               empty;
  logic               pos_in_list;
  logic               dump_start;
  logic               dump_last;
  logic [ValW-1:0]    res_value;
  logic [IndexW-1:0]  res_index;
  status_e            res_status;
  logic               res_last;
  cell_ctrl_t         ctrl;

  logic [ValW-1:0]    mod_tab [ModN];
  logic [ValW-1:0]    cell_val [LIST_DEPTH];
  logic [ValW-1:0]    new_val;

  for (genvar g = 0; g < ModN; g++) begin : g_mod
    assign mod_tab[g] = ValW'(g % VALUE_LIMIT);
  end

  assign new_val = mod_tab[entry_value_i];

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [ValW-1:0] left_v;
    logic [ValW-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = cell_val[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_inner
      assign right_v = cell_val[g+1];
    end
    pol_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .new_i  (new_val),
      .left_i (left_v),
      .right_i(right_v),
      .head_i (cell_val[0]),
      .value_o(cell_val[g])
    );
  end

  assign busy_o      = (state_q == ST_DUMP);
  assign accept      = start_i && !busy_o;
  assign full        = (count_q == CntW'(LIST_DEPTH));
  assign empty       = (count_q == '0);
  assign pos_in_list = (position_i < PosW'(count_q));
  assign dump_last   = (CntW'(dump_idx_q) == count_q - 1'b1);

  always_comb begin
    ctrl       = '{op: CELL_HOLD, at: '0, cnt: PosW'(count_q)};
    count_d    = count_q;
    res_value  = '0;
    res_index  = '0;
    res_status = STAT_OK;
    res_last   = 1'b1;
    dump_start = 1'b0;
    if (state_q == ST_DUMP) begin
      ctrl.op = CELL_ROTATE;
    end else if (accept) begin
      unique case (req_type_i)
        REQ_INS_HEAD, REQ_INS_POS, REQ_INS_TAIL: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            ctrl.op = CELL_INSERT;
            count_d = count_q + 1'b1;
            if (req_type_i == REQ_INS_HEAD ||
                (req_type_i == REQ_INS_POS && position_i == '0)) begin
              ctrl.at = '0;
            end else if (req_type_i == REQ_INS_POS && pos_in_list) begin
              ctrl.at = position_i;
            end else begin
              ctrl.at = PosW'(count_q);
              if (req_type_i == REQ_INS_POS) begin
                res_status = STAT_APPEND;
              end
            end
          end
        end
        REQ_READ: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else if (!pos_in_list) begin
            res_status = STAT_NOPOS;
          end else begin
            res_value = cell_val[position_i[IdxW-1:0]];
            res_index = IndexW'(position_i);
          end
        end
        REQ_DEL_HEAD, REQ_DEL_POS, REQ_DEL_TAIL: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else if (req_type_i == REQ_DEL_POS && !pos_in_list) begin
            res_status = STAT_NOPOS;
          end else begin
            ctrl.op = CELL_REMOVE;
            count_d = count_q - 1'b1;
            if (req_type_i == REQ_DEL_HEAD) begin
              ctrl.at = '0;
            end else if (req_type_i == REQ_DEL_TAIL) begin
              ctrl.at = PosW'(count_q - 1'b1);
            end else begin
              ctrl.at = position_i;
            end
          end
        end
        REQ_CLEAR: begin
          count_d = '0;
        end
        REQ_DUMP: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else begin
            ctrl.op    = CELL_ROTATE;
            dump_start = 1'b1;
            res_value  = cell_val[0];
            res_last   = (count_q == CntW'(1));
          end
        end
        default: begin
          res_status = STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      dump_idx_q <= '0;
      valid_q    <= 1'b0;
      last_q     <= 1'b0;
      value_q    <= '0;
      index_q    <= '0;
      status_q   <= STAT_OK;
    end else begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            valid_q  <= 1'b1;
            last_q   <= res_last;
            value_q  <= res_value;
            index_q  <= res_index;
            status_q <= res_status;
            count_q  <= count_d;
            if (dump_start && !res_last) begin
              state_q    <= ST_DUMP;
              dump_idx_q <= IdxW'(1);
            end
          end
        end
        ST_DUMP: begin
          valid_q    <= 1'b1;
          last_q     <= dump_last;
          value_q    <= cell_val[0];
          index_q    <= IndexW'(dump_idx_q);
          status_q   <= STAT_OK;
          dump_idx_q <= dump_idx_q + 1'b1;
          if (dump_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign valid_o       = valid_q;
  assign last_of_run_o = last_q;
  assign item_value_o  = value_q;
  assign item_index_o  = index_q;
  assign status_o      = status_q;
  assign entry_count_o = CountW'(count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(LIST_DEPTH))
    else $error("element count beyond list depth");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> count_q != '0)
    else $error("dump in progress on an empty list");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> valid_o)
    else $error("accepted transaction gave no result in the next cycle");

  a_dump_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> valid_o)
    else $error("gap in dump results");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_of_run_o) |-> busy_o)
    else $error("result not marked last while no dump is running");
`endif

endmodule

FILE: test/pol_list_checker.sv
module pol_list_checker
  import pol_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [ReqW-1:0]     req_type_i,
  input  logic [PosW-1:0]     position_i,
  input  logic [ValW-1:0]     entry_value_i,
  input  logic                valid_i,
  input  logic [ValW-1:0]     item_value_i,
  input  logic [IndexW-1:0]   item_index_i,
  input  logic [StatW-1:0]    status_i,
  input  logic [CountW-1:0]   entry_count_i,
  input  logic                last_of_run_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         list_len_o,
  output int unsigned         results_o,
  output int unsigned         full_refusals_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ValW-1:0]   value;
    logic [IndexW-1:0] index;
    logic [StatW-1:0]  status;
    logic [CountW-1:0] count;
    logic              last;
  } outcome_t;

  outcome_t        outcome_q[$];
  outcome_t        oldest;
  logic [ValW-1:0] cells[ListDepthDef];
  int unsigned     list_len = 0;
  int unsigned     mismatches = 0;
  int unsigned     results_seen = 0;
  int unsigned     full_refusals = 0;

  function automatic void push_outcome(logic [ValW-1:0] value, logic [IndexW-1:0] index,
                                       logic [StatW-1:0] status, logic last);
    outcome_t o;
    o.value  = value;
    o.index  = index;
    o.status = status;
    o.count  = CountW'(list_len);
    o.last   = last;
    outcome_q.push_back(o);
  endfunction

  task automatic insert_cell(int unsigned at, logic [ValW-1:0] value);
    for (int unsigned i = list_len; i > at; i--) begin
      cells[i] = cells[i-1];
    end
    cells[at] = value;
    list_len++;
  endtask

  task automatic remove_cell(int unsigned at);
    for (int unsigned i = at; i + 1 < list_len; i++) begin
      cells[i] = cells[i+1];
    end
    list_len--;
  endtask

  task automatic apply_request(logic [ReqW-1:0] req, logic [PosW-1:0] pos,
                               logic [ValW-1:0] raw);
    logic [ValW-1:0]  value;
    logic [StatW-1:0] status;
    bit               reported;
    value    = ValW'(raw % ValueLimitDef);
    status   = STAT_OK;
    reported = 1'b0;
    case (req)
      REQ_INS_HEAD, REQ_INS_POS, REQ_INS_TAIL: begin
        if (list_len >= ListDepthDef) begin
          status = STAT_FULL;
          full_refusals++;
        end else if (req == REQ_INS_HEAD || (req == REQ_INS_POS && pos == 0)) begin
          insert_cell(0, value);
        end else if (req == REQ_INS_POS && pos < list_len) begin
          insert_cell(pos, value);
        end else begin
          if (req == REQ_INS_POS) status = STAT_APPEND;
          insert_cell(list_len, value);
        end
      end
      REQ_READ: begin
        if (list_len == 0) begin
          status = STAT_EMPTY;
        end else if (pos >= list_len) begin
          status = STAT_NOPOS;
        end else begin
          push_outcome(cells[pos], IndexW'(pos), STAT_OK, 1'b1);
          reported = 1'b1;
        end
      end
      REQ_DEL_HEAD, REQ_DEL_POS, REQ_DEL_TAIL: begin
        if (list_len == 0) begin
          status = STAT_EMPTY;
        end else if (req == REQ_DEL_HEAD) begin
          remove_cell(0);
        end else if (req == REQ_DEL_TAIL) begin
          remove_cell(list_len - 1);
        end else if (pos >= list_len) begin
          status = STAT_NOPOS;
        end else begin
          remove_cell(pos);
        end
      end
      REQ_CLEAR: begin
        list_len = 0;
      end
      REQ_DUMP: begin
        if (list_len == 0) begin
          status = STAT_EMPTY;
        end else begin
          for (int unsigned i = 0; i < list_len; i++) begin
            push_outcome(cells[i], IndexW'(i), STAT_OK, i + 1 == list_len);
          end
          reported = 1'b1;
        end
      end
      default: ;
    endcase
    if (!reported) push_outcome('0, '0, status, 1'b1);
  endtask

  task automatic check_field(string field, int unsigned expected, int unsigned actual);
    if (expected != actual) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected,
               actual);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      outcome_q.delete();
      pending_o       <= 0;
      list_len_o      <= 0;
      fail_count_o    <= mismatches;
      results_o       <= results_seen;
      full_refusals_o <= full_refusals;
    end else begin
      if (valid_i) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual value %0d index %0d %s",
                   $time, item_value_i, item_index_i,
                   $sformatf("status %0d count %0d last %0b", status_i, entry_count_i,
                             last_of_run_i));
        end else begin
          oldest = outcome_q.pop_front();
          check_field("item_value", oldest.value, item_value_i);
          check_field("item_index", oldest.index, item_index_i);
          check_field("status", oldest.status, status_i);
          check_field("entry_count", oldest.count, entry_count_i);
          check_field("last_of_run", oldest.last, last_of_run_i);
        end
      end
      if (start_i && !busy_i) begin
        apply_request(req_type_i, position_i, entry_value_i);
      end
      pending_o       <= outcome_q.size();
      list_len_o      <= list_len;
      fail_count_o    <= mismatches;
      results_o       <= results_seen;
      full_refusals_o <= full_refusals;
    end
  end

endmodule

FILE: test/positional_ordered_list_tb.sv
module positional_ordered_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pol_pkg::*;

  localparam logic [ReqW-1:0] ReqUnknownFirst = 4'd9;
  localparam logic [ReqW-1:0] ReqUnknownLast  = 4'd15;
  localparam int unsigned     RandomItems     = 285;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [ReqW-1:0]     req_type_i;
  logic [PosW-1:0]     position_i;
  logic [ValW-1:0]     entry_value_i;
  logic                valid_o;
  logic [ValW-1:0]     item_value_o;
  logic [IndexW-1:0]   item_index_o;
  logic [StatW-1:0]    status_o;
  logic [CountW-1:0]   entry_count_o;
  logic                last_of_run_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned list_len;
  int unsigned results_seen;
  int unsigned full_refusals;
  int unsigned sent_per_req[16];
  int unsigned mode;
  bit          no_idle;

  positional_ordered_list u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .entry_value_i(entry_value_i),
    .valid_o      (valid_o),
    .item_value_o (item_value_o),
    .item_index_o (item_index_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .last_of_run_o(last_of_run_o)
  );

  pol_list_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .entry_value_i  (entry_value_i),
    .valid_i        (valid_o),
    .item_value_i   (item_value_o),
    .item_index_i   (item_index_o),
    .status_i       (status_o),
    .entry_count_i  (entry_count_o),
    .last_of_run_i  (last_of_run_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .list_len_o     (list_len),
    .results_o      (results_seen),
    .full_refusals_o(full_refusals)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL positional_ordered_list");
    $finish;
  end

  task automatic send_req(logic [ReqW-1:0] req, logic [PosW-1:0] pos,
                          logic [ValW-1:0] value);
    int unsigned gap;
    start_i       <= 1'b1;
    req_type_i    <= req;
    position_i    <= pos;
    entry_value_i <= value;
    do @(posedge clk_i); while (busy_o);
    sent_per_req[req]++;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained(int unsigned max_cycles);
    int unsigned waited;
    waited  = 0;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && waited < max_cycles) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic random_req();
    int unsigned      roll;
    int unsigned      pos_roll;
    int unsigned      ins_cut, read_cut, dump_cut, del_cut, clear_cut;
    logic [ReqW-1:0]  req;
    logic [PosW-1:0]  pos;
    case (mode)
      0:       begin ins_cut = 70; read_cut = 80; dump_cut = 86; del_cut = 95; clear_cut = 97; end
      1:       begin ins_cut = 25; read_cut = 40; dump_cut = 47; del_cut = 90; clear_cut = 93; end
      default: begin ins_cut = 40; read_cut = 55; dump_cut = 65; del_cut = 90; clear_cut = 94; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_cut)        req = ReqW'(REQ_INS_HEAD + $urandom_range(0, 2));
    else if (roll < read_cut)  req = REQ_READ;
    else if (roll < dump_cut)  req = REQ_DUMP;
    else if (roll < del_cut)   req = ReqW'(REQ_DEL_HEAD + $urandom_range(0, 2));
    else if (roll < clear_cut) req = REQ_CLEAR;
    else                       req = ReqW'($urandom_range(ReqUnknownFirst, ReqUnknownLast));
    pos_roll = $urandom_range(0, 99);
    if (pos_roll < 70)      pos = PosW'($urandom_range(0, list_len));
    else if (pos_roll < 85) pos = PosW'($urandom_range(0, 20));
    else                    pos = PosW'($urandom_range(0, 255));
    send_req(req, pos, ValW'($urandom_range(0, 127)));
  endtask

  initial begin
    int unsigned phase_left;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    req_type_i    = '0;
    position_i    = '0;
    entry_value_i = '0;
    no_idle       = 1'b0;
    mode          = 0;
    phase_left    = 0;
    foreach (sent_per_req[i]) sent_per_req[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list, then filled to the brim with the awkward positions and values first.
    send_req(REQ_DUMP, 8'd0, 7'd0);
    send_req(REQ_READ, 8'd0, 7'd0);
    send_req(REQ_DEL_TAIL, 8'd0, 7'd0);
    send_req(REQ_INS_POS, 8'd3, 7'd127);
    send_req(REQ_INS_HEAD, 8'd0, 7'd0);
    send_req(REQ_INS_POS, 8'd0, 7'd99);
    send_req(REQ_INS_POS, 8'd1, 7'd100);
    send_req(REQ_INS_POS, 8'd255, 7'd85);
    for (int k = 0; k < 11; k++) begin
      send_req(REQ_INS_TAIL, PosW'($urandom_range(0, 255)), ValW'($urandom_range(0, 127)));
    end
    send_req(REQ_INS_POS, 8'd2, 7'd1);
    send_req(REQ_INS_TAIL, 8'd0, 7'd64);
    send_req(REQ_DEL_POS, 8'd255, 7'd0);
    send_req(REQ_READ, 8'd15, 7'd0);
    send_req(REQ_DUMP, 8'd0, 7'd0);
    send_req(ReqUnknownLast, 8'd0, 7'd0);
    send_req(REQ_CLEAR, 8'd0, 7'd0);
    wait_drained(1000);

    for (int n = 0; n < RandomItems; n++) begin
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(15, 50);
        no_idle    = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 3) == 0) wait_drained(1000);
      end
      phase_left--;
      random_req();
    end

    wait_drained(2000);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d inserts, %0d reads, %0d deletes, %0d clears, %0d dumps and %0d unknown requests.",
             sent_per_req[REQ_INS_HEAD] + sent_per_req[REQ_INS_POS] + sent_per_req[REQ_INS_TAIL],
             sent_per_req[REQ_READ],
             sent_per_req[REQ_DEL_HEAD] + sent_per_req[REQ_DEL_POS] + sent_per_req[REQ_DEL_TAIL],
             sent_per_req[REQ_CLEAR], sent_per_req[REQ_DUMP],
             sent_per_req[9] + sent_per_req[10] + sent_per_req[11] + sent_per_req[12] +
             sent_per_req[13] + sent_per_req[14] + sent_per_req[15]);
    $display("Checked %0d results; %0d inserts met a full list; %0d results never arrived.",
             results_seen, full_refusals, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS positional_ordered_list");
    end else begin
      $display("FAIL positional_ordered_list");
    end
    $finish;
  end

endmodule
